/* design/p2paz_pkg.sv */
// Shared constants, types and the arctangent table of the sun-pointing pipeline.
// Used by the CORDIC cell, the CORDIC chain and the top level; no dependencies.
package p2paz_pkg;

   // Width of the CORDIC datapath (Q30 radians and scaled vectors).
   localparam int DW = 40;
   // Width of trigonometric values (Q30) between the rotation chains and the vectoring chains.
   localparam int TW = 34;

   localparam logic signed [DW-1:0] PI_Q30      = 40'sd3373259426;
   localparam logic signed [DW-1:0] HALF_PI_Q30 = 40'sd1686629713;
   localparam logic signed [DW-1:0] TWO_PI_Q30  = 40'sd6746518852;
   localparam logic signed [DW-1:0] INV_GAIN_Q30 = 40'sd652032874;
   localparam logic signed [TW-1:0] GAIN_Q30    = 34'sd1768195364;
   localparam logic signed [31:0]   D2R_Q32     = 32'sd74961321;
   localparam logic signed [31:0]   R2D_Q20     = 32'sd60078979;

   // Payload that travels beside the first vectoring chain.
   typedef struct packed {
      logic [24:0]        saz;
      logic signed [23:0] sel;
   } v1_side_type;

   // Payload beside the second vectoring chain.
   typedef struct packed {
      logic signed [DW-1:0] dir;
      logic [24:0]          saz;
      logic signed [23:0]   sel;
   } v2_side_type;

   // Payload beside the rotation chain of the shift magnitude.
   typedef struct packed {
      logic [22:0] mag_deg;
      logic [25:0] dir_deg;
   } rot_side_type;

   // Payload beside the last two vectoring chains; ang is the angle handed on.
   typedef struct packed {
      logic [22:0]          mag_deg;
      logic [25:0]          dir_deg;
      logic [24:0]          saz;
      logic signed [23:0]   sel;
      logic signed [DW-1:0] ang;
   } tail_side_type;

   // Arctangent of 2^-step in Q30 radians.
   function automatic logic signed [DW-1:0] atan_q30(input int step);
      logic signed [DW-1:0] r;
      case (step)
         0: r = 40'sd843314856;
         1: r = 40'sd497837829;
         2: r = 40'sd263043836;
         3: r = 40'sd133525158;
         4: r = 40'sd67021686;
         5: r = 40'sd33543515;
         6: r = 40'sd16775850;
         7: r = 40'sd8388437;
         8: r = 40'sd4194282;
         9: r = 40'sd2097149;
         10: r = 40'sd1048575;
         default: r = (step <= 30) ? $signed(DW'(1) << (30 - step)) : '0;
      endcase
      return r;
   endfunction

endpackage

/* design/pixel_to_pointing_azel_top.sv */
// Top level: pixel-to-screen mapping, CORDIC chains, rotation products and output register.
// Depends on p2paz_pkg and p2paz_cordic_chain.

// Maps a sun centroid pixel to a shift angle and direction, rotates the shift about the sun
// direction, and reports pointing azimuth/elevation and their offsets from the sun, with
// angles in units of 2^-ANGLE_FRACTION_BITS degree. One item is taken per clock cycle while
// the pipeline advances; each item passes through the five CORDIC chains in series, each of
// a range-reduction register and CORDIC_STEPS cells. The whole pipeline advances whenever
// the output register is empty or its result is being taken. Registers must be written
// through csr_we/csr_index/csr_wdata only while no item is in flight; the block does not check this.
module pixel_to_pointing_azel_top #(
   parameter int CORDIC_STEPS        = 24,
   parameter int ANGLE_FRACTION_BITS = 16,
   parameter int PIXEL_BITS          = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // pixel_x, pixel_y, sun_azimuth, sun_elevation (from bit 0 up), zero padded
   input  logic [((2*PIXEL_BITS+49+7)/8)*8-1:0]     req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // shift_magnitude, shift_direction, pointing_azimuth, pointing_elevation,
   // azimuth_offset, elevation_offset (from bit 0 up), zero padded
   output logic [151:0]                             rsp_tdata,
   input  logic                                     csr_we,
   input  logic [2:0]                               csr_index,
   input  logic [24:0]                              csr_wdata
);
   import p2paz_pkg::*;

   localparam int PB       = PIXEL_BITS;
   localparam int PROD_W   = PIXEL_BITS + 17;
   localparam int SAT_W    = PROD_W + 1;
   localparam int R2D_SH   = 50 - ANGLE_FRACTION_BITS;
   localparam int D2R_SH   = ANGLE_FRACTION_BITS + 2;
   localparam int RSP_BITS = 151;

   localparam logic [2:0] REG_INTERCEPT_X = 3'd0;
   localparam logic [2:0] REG_INTERCEPT_Y = 3'd1;
   localparam logic [2:0] REG_SLOPE_X     = 3'd2;
   localparam logic [2:0] REG_SLOPE_Y     = 3'd3;
   localparam logic [2:0] REG_CENTER_X    = 3'd4;
   localparam logic [2:0] REG_CENTER_Y    = 3'd5;
   localparam logic [2:0] REG_BENCH_DIST  = 3'd6;
   localparam logic [2:0] REG_CLOCKING    = 3'd7;

   localparam logic signed [PROD_W-1:0]  ROUND8   = 128;
   localparam logic signed [2*TW-1:0]    HALF30   = (2*TW)'(1) << 29;
   localparam logic signed [DW+31:0]     R2D_HALF = (DW+32)'(1) << (R2D_SH - 1);
   localparam logic signed [DW+31:0]     D2R_HALF = (DW+32)'(1) << (D2R_SH - 1);

   // Saturate to 16 bits signed.
   function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
      logic signed [15:0] r;
      if (v > 32767) begin
         r = 16'sh7fff;
      end else if (v < -32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Q30 product, rounded half up.
   function automatic logic signed [TW-1:0] mulq30(input logic signed [TW-1:0] a,
                                                   input logic signed [TW-1:0] b);
      logic signed [2*TW-1:0] p;
      p = a * b;
      return TW'((p + HALF30) >>> 30);
   endfunction

   // Q30 radians to output angle units, rounded half up.
   function automatic logic signed [DW-1:0] rad_to_deg(input logic signed [DW-1:0] r);
      logic signed [DW+31:0] p;
      p = r * R2D_Q20;
      return DW'((p + R2D_HALF) >>> R2D_SH);
   endfunction

   // Output angle units to Q30 radians, rounded half up.
   function automatic logic signed [DW-1:0] deg_to_rad(input logic signed [DW-1:0] d);
      logic signed [DW+31:0] p;
      p = d * D2R_Q32;
      return DW'((p + D2R_HALF) >>> D2R_SH);
   endfunction

   logic en;

   // Configuration registers.
   logic signed [15:0] intercept_x_ff, intercept_y_ff, slope_x_ff, slope_y_ff;
   logic signed [15:0] center_x_ff, center_y_ff;
   logic [15:0]        bench_distance_ff;
   logic signed [24:0] clocking_angle_ff;
   logic signed [DW-1:0] dist_k_ff, dist_k_in, clock_rad_ff;
   logic [47:0]          dk_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         intercept_x_ff    <= -16'sd3000;
         intercept_y_ff    <= 16'sd3000;
         slope_x_ff        <= 16'sd1536;
         slope_y_ff        <= -16'sd1536;
         center_x_ff       <= '0;
         center_y_ff       <= '0;
         bench_distance_ff <= 16'd3000;
         clocking_angle_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_INTERCEPT_X: intercept_x_ff    <= csr_wdata[15:0];
            REG_INTERCEPT_Y: intercept_y_ff    <= csr_wdata[15:0];
            REG_SLOPE_X:     slope_x_ff        <= csr_wdata[15:0];
            REG_SLOPE_Y:     slope_y_ff        <= csr_wdata[15:0];
            REG_CENTER_X:    center_x_ff       <= csr_wdata[15:0];
            REG_CENTER_Y:    center_y_ff       <= csr_wdata[15:0];
            REG_BENCH_DIST:  bench_distance_ff <= csr_wdata[15:0];
            REG_CLOCKING:    clocking_angle_ff <= csr_wdata;
            default:         clocking_angle_ff <= clocking_angle_ff;
         endcase
      end
   end

   // Values that follow from the registers alone: gain-matched bench distance and clocking in radians.
   assign dk_prod   = bench_distance_ff * 48'd1768195364;
   assign dist_k_in = DW'((dk_prod + 48'd32768) >> 16);

   always_ff @(posedge clock) begin
      dist_k_ff    <= dist_k_in;
      clock_rad_ff <= deg_to_rad(DW'(clocking_angle_ff));
   end

   // Global advance: the output register is empty or its result is transferred.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Stage 1: slope times pixel.
   logic                     s1_valid_ff;
   logic signed [PROD_W-1:0] s1_prod_x_ff, s1_prod_y_ff;
   logic [24:0]              s1_saz_ff;
   logic signed [23:0]       s1_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_x_ff <= slope_x_ff * $signed({1'b0, req_tdata[PB-1:0]});
         s1_prod_y_ff <= slope_y_ff * $signed({1'b0, req_tdata[2*PB-1:PB]});
         s1_saz_ff    <= req_tdata[2*PB+24:2*PB];
         s1_sel_ff    <= req_tdata[2*PB+48:2*PB+25];
      end
   end

   // Stage 2: screen position and offset from the center, both saturated.
   logic signed [SAT_W-1:0] sum_x, sum_y, dxr, dyr;
   logic signed [15:0]      sx, sy;
   logic                    s2_valid_ff;
   logic signed [15:0]      s2_dx_ff, s2_dy_ff;
   logic [24:0]             s2_saz_ff;
   logic signed [23:0]      s2_sel_ff;

   always_comb begin
      sum_x = intercept_x_ff + ((s1_prod_x_ff + ROUND8) >>> 8);
      sum_y = intercept_y_ff + ((s1_prod_y_ff + ROUND8) >>> 8);
      sx    = sat16(sum_x);
      sy    = sat16(sum_y);
      dxr   = center_x_ff - sx;
      dyr   = center_y_ff - sy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_dx_ff  <= sat16(dxr);
         s2_dy_ff  <= sat16(dyr);
         s2_saz_ff <= s1_saz_ff;
         s2_sel_ff <= s1_sel_ff;
      end
   end

   // First vectoring chain: direction and length of the screen shift.
   v1_side_type          v1_src, v1_dst;
   logic                 v1_valid;
   logic signed [DW-1:0] v1_x, v1_z;

   assign v1_src = '{saz: s2_saz_ff, sel: s2_sel_ff};

   p2paz_cordic_chain #(
      .STEPS  (CORDIC_STEPS),
      .ROTATE (1'b0),
      .SIDE_W ($bits(v1_side_type))
   ) u_vec_shift (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .src_valid (s2_valid_ff),
      .src_x     (DW'(s2_dy_ff) <<< 14),
      .src_y     (DW'(s2_dx_ff) <<< 14),
      .src_z     ('0),
      .src_side  (v1_src),
      .dst_valid (v1_valid),
      .dst_x     (v1_x),
      .dst_y     (),
      .dst_z     (v1_z),
      .dst_side  (v1_dst)
   );

   // Second vectoring chain: shift angle from length against bench distance.
   v2_side_type          v2_src, v2_dst;
   logic                 v2_valid;
   logic signed [DW-1:0] v2_z;

   assign v2_src = '{dir: v1_z, saz: v1_dst.saz, sel: v1_dst.sel};

   p2paz_cordic_chain #(
      .STEPS  (CORDIC_STEPS),
      .ROTATE (1'b0),
      .SIDE_W ($bits(v2_side_type))
   ) u_vec_mag (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .src_valid (v1_valid),
      .src_x     (dist_k_ff),
      .src_y     (v1_x),
      .src_z     ('0),
      .src_side  (v2_src),
      .dst_valid (v2_valid),
      .dst_x     (),
      .dst_y     (),
      .dst_z     (v2_z),
      .dst_side  (v2_dst)
   );

   // Angle stage: clamp the magnitude, convert to degrees, add clocking, elevation to radians.
   logic signed [DW-1:0] mag_r, dir_deg_full;
   logic                 p_valid_ff;
   logic signed [DW-1:0] p_mag_ff, p_dirr_ff, p_selr_ff;
   rot_side_type         p_side_ff;
   logic [24:0]          p_saz_ff;
   logic [23:0]          p_sel_ff;

   always_comb begin
      mag_r        = (v2_z < 0) ? '0 : v2_z;
      dir_deg_full = rad_to_deg(v2_dst.dir) + DW'(clocking_angle_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= v2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_mag_ff          <= mag_r;
         p_dirr_ff         <= v2_dst.dir + clock_rad_ff;
         p_selr_ff         <= deg_to_rad(DW'(v2_dst.sel));
         p_side_ff.mag_deg <= 23'(rad_to_deg(mag_r));
         p_side_ff.dir_deg <= dir_deg_full[25:0];
         p_saz_ff          <= v2_dst.saz;
         p_sel_ff          <= v2_dst.sel;
      end
   end

   // Three rotation chains in parallel: sin/cos of magnitude, direction and sun elevation.
   logic                 ra_valid;
   logic signed [DW-1:0] ra_x, ra_y, rb_x, rb_y, rc_x, rc_y;
   rot_side_type         ra_side;
   logic [24:0]          rb_saz;
   logic [23:0]          rc_sel;

   p2paz_cordic_chain #(
      .STEPS  (CORDIC_STEPS),
      .ROTATE (1'b1),
      .SIDE_W ($bits(rot_side_type))
   ) u_rot_mag (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .src_valid (p_valid_ff),
      .src_x     (INV_GAIN_Q30),
      .src_y     ('0),
      .src_z     (p_mag_ff),
      .src_side  (p_side_ff),
      .dst_valid (ra_valid),
      .dst_x     (ra_x),
      .dst_y     (ra_y),
      .dst_z     (),
      .dst_side  (ra_side)
   );

   p2paz_cordic_chain #(
      .STEPS  (CORDIC_STEPS),
      .ROTATE (1'b1),
      .SIDE_W (25)
   ) u_rot_dir (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .src_valid (p_valid_ff),
      .src_x     (INV_GAIN_Q30),
      .src_y     ('0),
      .src_z     (p_dirr_ff),
      .src_side  (p_saz_ff),
      .dst_valid (),
      .dst_x     (rb_x),
      .dst_y     (rb_y),
      .dst_z     (),
      .dst_side  (rb_saz)
   );

   p2paz_cordic_chain #(
      .STEPS  (CORDIC_STEPS),
      .ROTATE (1'b1),
      .SIDE_W (24)
   ) u_rot_elev (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .src_valid (p_valid_ff),
      .src_x     (INV_GAIN_Q30),
      .src_y     ('0),
      .src_z     (p_selr_ff),
      .src_side  (p_sel_ff),
      .dst_valid (),
      .dst_x     (rc_x),
      .dst_y     (rc_y),
      .dst_z     (),
      .dst_side  (rc_sel)
   );

   // Product stage 1: shift vector in the bench frame.
   logic              q1_valid_ff;
   logic signed [TW-1:0] q1_x0_ff, q1_y0_ff, q1_z0_ff, q1_se_ff, q1_ce_ff;
   rot_side_type      q1_side_ff;
   logic [24:0]       q1_saz_ff;
   logic signed [23:0] q1_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
      end else if (en) begin
         q1_valid_ff <= ra_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_x0_ff   <= mulq30(TW'(ra_y), TW'(rb_x));
         q1_y0_ff   <= mulq30(TW'(ra_y), TW'(rb_y));
         q1_z0_ff   <= TW'(ra_x);
         q1_se_ff   <= TW'(rc_y);
         q1_ce_ff   <= TW'(rc_x);
         q1_side_ff <= ra_side;
         q1_saz_ff  <= rb_saz;
         q1_sel_ff  <= rc_sel;
      end
   end

   // Product stage 2: tilt by the sun elevation.
   logic              q2_valid_ff;
   logic signed [TW-1:0] q2_x1_ff, q2_y0_ff, q2_z1_ff;
   rot_side_type      q2_side_ff;
   logic [24:0]       q2_saz_ff;
   logic signed [23:0] q2_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q2_valid_ff <= 1'b0;
      end else if (en) begin
         q2_valid_ff <= q1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q2_x1_ff   <= mulq30(q1_z0_ff, q1_ce_ff) - mulq30(q1_x0_ff, q1_se_ff);
         q2_z1_ff   <= mulq30(q1_x0_ff, q1_ce_ff) + mulq30(q1_z0_ff, q1_se_ff);
         q2_y0_ff   <= q1_y0_ff;
         q2_side_ff <= q1_side_ff;
         q2_saz_ff  <= q1_saz_ff;
         q2_sel_ff  <= q1_sel_ff;
      end
   end

   // Product stage 3: gain-match the vertical component and negate x.
   logic              q3_valid_ff;
   logic signed [TW-1:0] q3_nx1_ff, q3_y0_ff, q3_z1k_ff;
   rot_side_type      q3_side_ff;
   logic [24:0]       q3_saz_ff;
   logic signed [23:0] q3_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q3_valid_ff <= 1'b0;
      end else if (en) begin
         q3_valid_ff <= q2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q3_nx1_ff  <= -q2_x1_ff;
         q3_y0_ff   <= q2_y0_ff;
         q3_z1k_ff  <= mulq30(q2_z1_ff, GAIN_Q30);
         q3_side_ff <= q2_side_ff;
         q3_saz_ff  <= q2_saz_ff;
         q3_sel_ff  <= q2_sel_ff;
      end
   end

   // Third vectoring chain: azimuth offset and horizontal length.
   tail_side_type        v3_src, v3_dst;
   logic                 v3_valid;
   logic signed [DW-1:0] v3_x, v3_z;

   assign v3_src = '{mag_deg: q3_side_ff.mag_deg, dir_deg: q3_side_ff.dir_deg,
                     saz: q3_saz_ff, sel: q3_sel_ff, ang: DW'(q3_z1k_ff)};

   p2paz_cordic_chain #(
      .STEPS  (CORDIC_STEPS),
      .ROTATE (1'b0),
      .SIDE_W ($bits(tail_side_type))
   ) u_vec_az (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .src_valid (q3_valid_ff),
      .src_x     (DW'(q3_nx1_ff)),
      .src_y     (DW'(q3_y0_ff)),
      .src_z     ('0),
      .src_side  (v3_src),
      .dst_valid (v3_valid),
      .dst_x     (v3_x),
      .dst_y     (),
      .dst_z     (v3_z),
      .dst_side  (v3_dst)
   );

   // Fourth vectoring chain: pointing elevation.
   tail_side_type        v4_src, v4_dst;
   logic                 v4_valid;
   logic signed [DW-1:0] v4_z;

   assign v4_src = '{mag_deg: v3_dst.mag_deg, dir_deg: v3_dst.dir_deg,
                     saz: v3_dst.saz, sel: v3_dst.sel, ang: v3_z};

   p2paz_cordic_chain #(
      .STEPS  (CORDIC_STEPS),
      .ROTATE (1'b0),
      .SIDE_W ($bits(tail_side_type))
   ) u_vec_el (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .src_valid (v3_valid),
      .src_x     (v3_x),
      .src_y     (v3_dst.ang),
      .src_z     ('0),
      .src_side  (v4_src),
      .dst_valid (v4_valid),
      .dst_x     (),
      .dst_y     (),
      .dst_z     (v4_z),
      .dst_side  (v4_dst)
   );

   // Output register: convert to degrees and form the unwrapped azimuth and the offsets.
   logic signed [DW-1:0] daz_deg, pel_deg, paz, eoff;
   logic                 out_valid_ff;
   logic [RSP_BITS-1:0]  out_data_ff;

   always_comb begin
      daz_deg = rad_to_deg(v4_dst.ang);
      pel_deg = rad_to_deg(v4_z);
      paz     = $signed({{(DW-25){1'b0}}, v4_dst.saz}) + daz_deg;
      eoff    = pel_deg - DW'(v4_dst.sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v4_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= {eoff[24:0], daz_deg[25:0], pel_deg[23:0], paz[26:0],
                         v4_dst.dir_deg, v4_dst.mag_deg};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

endmodule

/* design/p2paz_cordic_cell.sv */
// One micro-rotation of a CORDIC, registered, with the payload carried beside it.
// Depends on p2paz_pkg for the datapath width and the arctangent table.
module p2paz_cordic_cell #(
   parameter int STEP   = 0,
   parameter bit ROTATE = 1'b0,
   parameter int SIDE_W = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           src_valid,
   input  logic                           src_flag,
   input  logic signed [p2paz_pkg::DW-1:0] src_x,
   input  logic signed [p2paz_pkg::DW-1:0] src_y,
   input  logic signed [p2paz_pkg::DW-1:0] src_z,
   input  logic [SIDE_W-1:0]              src_side,
   output logic                           dst_valid,
   output logic                           dst_flag,
   output logic signed [p2paz_pkg::DW-1:0] dst_x,
   output logic signed [p2paz_pkg::DW-1:0] dst_y,
   output logic signed [p2paz_pkg::DW-1:0] dst_z,
   output logic [SIDE_W-1:0]              dst_side
);
   import p2paz_pkg::*;

   localparam logic signed [DW-1:0] ATAN = atan_q30(STEP);

   logic                 valid_ff, flag_ff;
   logic signed [DW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic [SIDE_W-1:0]    side_ff;
   logic                 ccw;
   logic signed [DW-1:0] xs, ys;

   // Counterclockwise when the angle residue is not negative (rotation) or y is not positive.
   always_comb begin
      ccw = ROTATE ? (src_z >= 0) : !(src_y > 0);
      xs  = src_x >>> STEP;
      ys  = src_y >>> STEP;
      if (ccw) begin
         x_in = src_x - ys;
         y_in = src_y + xs;
         z_in = src_z - ATAN;
      end else begin
         x_in = src_x + ys;
         y_in = src_y - xs;
         z_in = src_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flag_ff <= src_flag;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= src_side;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_flag  = flag_ff;
   assign dst_x     = x_ff;
   assign dst_y     = y_ff;
   assign dst_z     = z_ff;
   assign dst_side  = side_ff;

endmodule

/* design/p2paz_cordic_chain.sv */
// A full CORDIC as a row of cells: a range-reduction stage, STEPS cells, and output fix-up.
// Depends on p2paz_pkg and p2paz_cordic_cell.
module p2paz_cordic_chain #(
   parameter int STEPS  = 24,
   parameter bit ROTATE = 1'b0,
   parameter int SIDE_W = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           src_valid,
   input  logic signed [p2paz_pkg::DW-1:0] src_x,
   input  logic signed [p2paz_pkg::DW-1:0] src_y,
   input  logic signed [p2paz_pkg::DW-1:0] src_z,
   input  logic [SIDE_W-1:0]              src_side,
   output logic                           dst_valid,
   output logic signed [p2paz_pkg::DW-1:0] dst_x,
   output logic signed [p2paz_pkg::DW-1:0] dst_y,
   output logic signed [p2paz_pkg::DW-1:0] dst_z,
   output logic [SIDE_W-1:0]              dst_side
);
   import p2paz_pkg::*;

   logic                 pv_ff, pf_ff, pf_in;
   logic signed [DW-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic [SIDE_W-1:0]    ps_ff;

   logic                 cv [STEPS+1];
   logic                 cf [STEPS+1];
   logic signed [DW-1:0] cx [STEPS+1];
   logic signed [DW-1:0] cy [STEPS+1];
   logic signed [DW-1:0] cz [STEPS+1];
   logic [SIDE_W-1:0]    cs [STEPS+1];

   // Range reduction. Vectoring: flag a zero vector and fold the left half plane by pi.
   // Rotation: wrap into [-pi, pi], then fold into [-pi/2, pi/2] and flag the negation.
   always_comb begin
      px_in = src_x;
      py_in = src_y;
      pz_in = src_z;
      pf_in = 1'b0;
      if (ROTATE) begin
         if (src_z > PI_Q30) begin
            pz_in = src_z - TWO_PI_Q30;
         end else if (src_z < -PI_Q30) begin
            pz_in = src_z + TWO_PI_Q30;
         end
         if (pz_in > HALF_PI_Q30) begin
            pz_in = pz_in - PI_Q30;
            pf_in = 1'b1;
         end else if (pz_in < -HALF_PI_Q30) begin
            pz_in = pz_in + PI_Q30;
            pf_in = 1'b1;
         end
      end else begin
         pf_in = (src_x == 0) && (src_y == 0);
         if (src_x < 0) begin
            pz_in = (src_y >= 0) ? PI_Q30 : -PI_Q30;
            px_in = -src_x;
            py_in = -src_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pf_ff <= pf_in;
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
         ps_ff <= src_side;
      end
   end

   assign cv[0] = pv_ff;
   assign cf[0] = pf_ff;
   assign cx[0] = px_ff;
   assign cy[0] = py_ff;
   assign cz[0] = pz_ff;
   assign cs[0] = ps_ff;

   // The row of micro-rotation cells.
   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      p2paz_cordic_cell #(
         .STEP   (i),
         .ROTATE (ROTATE),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .src_valid (cv[i]),
         .src_flag  (cf[i]),
         .src_x     (cx[i]),
         .src_y     (cy[i]),
         .src_z     (cz[i]),
         .src_side  (cs[i]),
         .dst_valid (cv[i+1]),
         .dst_flag  (cf[i+1]),
         .dst_x     (cx[i+1]),
         .dst_y     (cy[i+1]),
         .dst_z     (cz[i+1]),
         .dst_side  (cs[i+1])
      );
   end

   // Fix-up: a zero vector gives angle and length zero; a folded rotation negates sin and cos.
   always_comb begin
      dst_x = cx[STEPS];
      dst_y = cy[STEPS];
      dst_z = cz[STEPS];
      if (ROTATE) begin
         if (cf[STEPS]) begin
            dst_x = -cx[STEPS];
            dst_y = -cy[STEPS];
         end
      end else if (cf[STEPS]) begin
         dst_x = '0;
         dst_z = '0;
      end
   end

   assign dst_valid = cv[STEPS];
   assign dst_side  = cs[STEPS];

endmodule
